[src/gda_pkg.sv]
// gda_pkg: shared types, constants and calendar functions for the
// gregorian date add/subtract block; no dependencies
package gda_pkg;

	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int CountW = 16;
	localparam int RemW   = CountW + 1;
	localparam int CentW  = 7;

	// operation codes on the kind field
	localparam logic KindAdd = 1'b0;
	localparam logic KindSub = 1'b1;

	localparam logic [YearW-1:0]  YearMin = 14'd1;
	localparam logic [YearW-1:0]  YearMax = 14'd9999;
	localparam logic [MonthW-1:0] MonJan  = 4'd1;
	localparam logic [MonthW-1:0] MonFeb  = 4'd2;
	localparam logic [MonthW-1:0] MonApr  = 4'd4;
	localparam logic [MonthW-1:0] MonJun  = 4'd6;
	localparam logic [MonthW-1:0] MonSep  = 4'd9;
	localparam logic [MonthW-1:0] MonNov  = 4'd11;
	localparam logic [MonthW-1:0] MonDec  = 4'd12;
	localparam logic [DayW-1:0]   LenLong = 5'd31;
	localparam logic [DayW-1:0]   LenShort = 5'd30;
	localparam logic [DayW-1:0]   LenFebLeap = 5'd29;
	localparam logic [DayW-1:0]   LenFeb = 5'd28;

	// year / 100 as (year * 5243) >> 19, exact for any 14-bit year
	localparam int CentRecipW = 13;
	localparam logic [CentRecipW-1:0] CentRecip = 13'd5243;
	localparam int CentShift = 19;
	localparam int CentProdW = YearW + CentRecipW;
	localparam logic [CentW-1:0] YearsPerCentM1 = 7'd99;
	localparam logic [YearW-1:0] YearsPerCent = 14'd100;

	typedef struct packed {
		logic load;
		logic century;
		logic split;
		logic init;
		logic step;
		logic capture;
	} gda_cmd_t;

	typedef struct packed {
		logic oor;
		logic stop;
	} gda_sts_t;

	// 4/100/400 rule on year split into century and year within century
	function automatic logic is_leap(input logic [CentW-1:0] cent,
			input logic [CentW-1:0] yic);
		logic by4;
		logic cent_yr;
		by4 = (yic[1:0] == 2'd0);
		cent_yr = (yic == '0);
		return by4 && (!cent_yr || (cent[1:0] == 2'd0));
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic leap,
			input logic [MonthW-1:0] m);
		logic [DayW-1:0] len;
		case (m)
			MonFeb: len = leap ? LenFebLeap : LenFeb;
			MonApr, MonJun, MonSep, MonNov: len = LenShort;
			default: len = LenLong;
		endcase
		return len;
	endfunction

endpackage

[src/gda_dp.sv]
// gda_dp: datapath of the date walker, holds the date, remaining days and
// leap tracking counters; depends on gda_pkg
module gda_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gda_pkg::gda_cmd_t              cmd,
	output gda_pkg::gda_sts_t              sts,
	input  logic                           kind,
	input  logic [gda_pkg::YearW-1:0]      start_year,
	input  logic [gda_pkg::MonthW-1:0]     start_month,
	input  logic [gda_pkg::DayW-1:0]       start_day,
	input  logic [gda_pkg::CountW-1:0]     day_count,
	output logic [gda_pkg::YearW-1:0]      result_year,
	output logic [gda_pkg::MonthW-1:0]     result_month,
	output logic [gda_pkg::DayW-1:0]       result_day,
	output logic                           out_of_range
);

	logic                          kind_q;
	logic [gda_pkg::YearW-1:0]     sy_q;
	logic [gda_pkg::MonthW-1:0]    sm_q;
	logic [gda_pkg::DayW-1:0]      sd_q;
	logic [gda_pkg::CountW-1:0]    cnt_q;
	logic [gda_pkg::YearW-1:0]     y_q;
	logic [gda_pkg::MonthW-1:0]    m_q;
	logic [gda_pkg::DayW-1:0]      d_q;
	logic [gda_pkg::RemW-1:0]      rem_q;
	logic [gda_pkg::CentW-1:0]     cent_q;
	logic [gda_pkg::CentW-1:0]     yic_q;
	logic                          oor_q;

	logic [gda_pkg::MonthW-1:0]    m_clamp;
	logic                          year_bad;
	logic [gda_pkg::CentProdW-1:0] cent_prod;
	logic [gda_pkg::YearW-1:0]     cent_x100;
	logic                          leap_cur;
	logic [gda_pkg::DayW-1:0]      len_cur;
	logic [gda_pkg::DayW-1:0]      len_prev;
	logic [gda_pkg::DayW-1:0]      d_clamp;
	logic                          add_fit;
	logic                          sub_fit;
	logic                          walk_done;
	logic                          hit_edge;
	logic                          advance;

	always_comb begin
		if (start_month == '0) begin
			m_clamp = gda_pkg::MonJan;
		end else if (start_month > gda_pkg::MonDec) begin
			m_clamp = gda_pkg::MonDec;
		end else begin
			m_clamp = start_month;
		end
	end

	assign year_bad = (start_year < gda_pkg::YearMin) || (start_year > gda_pkg::YearMax);

	assign cent_prod = gda_pkg::CentProdW'(y_q) * gda_pkg::CentProdW'(gda_pkg::CentRecip);
	assign cent_x100 = gda_pkg::YearW'(cent_q) * gda_pkg::YearsPerCent;

	assign leap_cur = gda_pkg::is_leap(cent_q, yic_q);
	assign len_cur  = gda_pkg::month_len(leap_cur, m_q);
	assign len_prev = gda_pkg::month_len(leap_cur, m_q - 4'd1);

	always_comb begin
		if (sd_q == '0) begin
			d_clamp = 5'd1;
		end else if (sd_q > len_cur) begin
			d_clamp = len_cur;
		end else begin
			d_clamp = sd_q;
		end
	end

	assign add_fit   = rem_q <= gda_pkg::RemW'(len_cur);
	assign sub_fit   = rem_q < gda_pkg::RemW'(d_q);
	assign walk_done = (kind_q == gda_pkg::KindSub) ? sub_fit : add_fit;
	assign hit_edge  = !walk_done && ((kind_q == gda_pkg::KindSub)
		? ((m_q == gda_pkg::MonJan) && (y_q == gda_pkg::YearMin))
		: ((m_q == gda_pkg::MonDec) && (y_q == gda_pkg::YearMax)));
	assign advance   = cmd.step && !walk_done && !hit_edge;

	assign sts.oor  = oor_q;
	assign sts.stop = walk_done || hit_edge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_q <= 1'b0;
		end else if (cmd.load) begin
			oor_q <= year_bad;
		end else if (cmd.step && hit_edge) begin
			oor_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			sy_q   <= start_year;
			sm_q   <= start_month;
			sd_q   <= start_day;
			cnt_q  <= day_count;
			y_q    <= start_year;
			m_q    <= m_clamp;
		end
		if (cmd.century) begin
			cent_q <= cent_prod[gda_pkg::CentShift +: gda_pkg::CentW];
		end
		if (cmd.split) begin
			yic_q <= gda_pkg::CentW'(y_q - cent_x100);
		end
		if (cmd.init) begin
			d_q <= d_clamp;
			if (kind_q == gda_pkg::KindSub) begin
				rem_q <= gda_pkg::RemW'(cnt_q);
			end else begin
				rem_q <= gda_pkg::RemW'(d_clamp) + gda_pkg::RemW'(cnt_q);
			end
		end
		if (cmd.step && walk_done) begin
			d_q <= (kind_q == gda_pkg::KindSub) ? (d_q - rem_q[gda_pkg::DayW-1:0])
				: rem_q[gda_pkg::DayW-1:0];
		end
		if (advance) begin
			if (kind_q == gda_pkg::KindAdd) begin
				rem_q <= rem_q - gda_pkg::RemW'(len_cur);
				if (m_q == gda_pkg::MonDec) begin
					m_q <= gda_pkg::MonJan;
					y_q <= y_q + 14'd1;
					if (yic_q == gda_pkg::YearsPerCentM1) begin
						yic_q  <= '0;
						cent_q <= cent_q + 7'd1;
					end else begin
						yic_q <= yic_q + 7'd1;
					end
				end else begin
					m_q <= m_q + 4'd1;
				end
			end else begin
				rem_q <= rem_q - gda_pkg::RemW'(d_q);
				if (m_q == gda_pkg::MonJan) begin
					m_q <= gda_pkg::MonDec;
					y_q <= y_q - 14'd1;
					d_q <= gda_pkg::LenLong;
					if (yic_q == '0) begin
						yic_q  <= gda_pkg::YearsPerCentM1;
						cent_q <= cent_q - 7'd1;
					end else begin
						yic_q <= yic_q - 7'd1;
					end
				end else begin
					m_q <= m_q - 4'd1;
					d_q <= len_prev;
				end
			end
		end
		if (cmd.capture) begin
			out_of_range <= oor_q;
			result_year  <= oor_q ? sy_q : y_q;
			result_month <= oor_q ? sm_q : m_q;
			result_day   <= oor_q ? sd_q : d_q;
		end
	end

`ifndef SYNTHESIS
	a_month_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (m_q >= gda_pkg::MonJan) && (m_q <= gda_pkg::MonDec))
		else $error("month left 1..12 during walk");
	a_yic_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (yic_q <= gda_pkg::YearsPerCentM1))
		else $error("year within century out of range");
	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture && !oor_q |-> (d_q != '0))
		else $error("day of month is zero at capture");
`endif

endmodule

[src/gda_ctrl.sv]
// gda_ctrl: sequencer of the date walker, drives datapath commands and
// both handshakes; depends on gda_pkg
module gda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output gda_pkg::gda_cmd_t cmd,
	input  gda_pkg::gda_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CENT,
		S_SPLIT,
		S_INIT,
		S_WALK,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.load    = (state_q == S_IDLE) && item_valid;
		cmd.century = (state_q == S_CENT);
		cmd.split   = (state_q == S_SPLIT);
		cmd.init    = (state_q == S_INIT);
		cmd.step    = (state_q == S_WALK);
		cmd.capture = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_CENT;
					end
				end
				S_CENT: begin
					state_q <= sts.oor ? S_FINISH : S_SPLIT;
				end
				S_SPLIT: begin
					state_q <= S_INIT;
				end
				S_INIT: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (sts.stop) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> (state_q == S_CENT))
		else $error("accepted beat did not start the walk");
	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || result_ready))
		else $error("result overwritten before it was taken");
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) && ($past(state_q) != S_WALK) |-> ($past(state_q) == S_INIT))
		else $error("walk entered without setup");
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.load)
		else $error("load issued while busy");
`endif

endmodule

[src/gregorian_date_add_subtract.sv]
// gregorian_date_add_subtract: top level of the date add/subtract block,
// joins gda_ctrl and gda_dp; depends on gda_pkg
//
// channel   valid          ready          payload
// input     item_valid     item_ready     kind, start_year, start_month, start_day, day_count
// result    result_valid   result_ready   result_year, result_month, result_day, out_of_range
//
// an item goes through the setup steps (accept, century, split, day clamp),
// then the month walk, one month per cycle plus a step that finds the end,
// then the result register load; a bad start year skips from the century
// step straight to the result load
// one item at a time: item_ready is high only while the sequencer is idle
// the result register holds a finished beat while the next item is taken
// a stalled result beat only delays the return to idle of the next item
// arst_n clears the sequencer and result valid; date registers need no reset
module gregorian_date_add_subtract (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           kind,
	input  logic [gda_pkg::YearW-1:0]      start_year,
	input  logic [gda_pkg::MonthW-1:0]     start_month,
	input  logic [gda_pkg::DayW-1:0]       start_day,
	input  logic [gda_pkg::CountW-1:0]     day_count,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [gda_pkg::YearW-1:0]      result_year,
	output logic [gda_pkg::MonthW-1:0]     result_month,
	output logic [gda_pkg::DayW-1:0]       result_day,
	output logic                           out_of_range
);

	// commands from sequencer to datapath, status back
	gda_pkg::gda_cmd_t cmd;
	gda_pkg::gda_sts_t sts;

	// sequencer: setup steps (century split, day clamp), month walk, result load
	gda_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	// datapath: date registers, remaining day count, leap tracking by
	// century and year within century, result register
	gda_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.start_year   (start_year),
		.start_month  (start_month),
		.start_day    (start_day),
		.day_count    (day_count),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.out_of_range (out_of_range)
	);

endmodule

[test/gregorian_date_add_subtract_test.sv]
// gregorian_date_add_subtract_test: self-checking bench for the date add/subtract block
// predicts each result date from its own calendar walk and checks every result beat
// depends on gda_pkg and gregorian_date_add_subtract
module gregorian_date_add_subtract_test;

	// cycles with no beat on either channel before the run is declared hung;
	// the slowest item walks about 2200 months, far below this
	localparam int StallLimit = 20000;
	// length of the forced result stall in the backpressure test
	localparam int HoldCycles = 400;

	// one expected result beat
	typedef struct packed {
		logic [gda_pkg::YearW-1:0]  year;
		logic [gda_pkg::MonthW-1:0] month;
		logic [gda_pkg::DayW-1:0]   day;
		logic                       oor;
	} date_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input channel, driven from time zero
	logic                         item_valid = 1'b0;
	logic                         item_ready;
	logic                         kind = gda_pkg::KindAdd;
	logic [gda_pkg::YearW-1:0]    start_year = '0;
	logic [gda_pkg::MonthW-1:0]   start_month = '0;
	logic [gda_pkg::DayW-1:0]     start_day = '0;
	logic [gda_pkg::CountW-1:0]   day_count = '0;

	// result channel
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic [gda_pkg::YearW-1:0]    result_year;
	logic [gda_pkg::MonthW-1:0]   result_month;
	logic [gda_pkg::DayW-1:0]     result_day;
	logic                         out_of_range;

	// expected result beats, oldest first
	date_beat_t pending_dates[$];

	int send_gap_pct = 0;     // chance per cycle that the sender holds back
	int recv_stall_pct = 0;   // chance per cycle that the receiver drops ready
	int hold_asked = 0;       // bumped by a test to start one long result stall
	int mismatches = 0;
	int dates_sent = 0;
	int results_seen = 0;
	int results_oor = 0;
	int idle_cycles = 0;

	gregorian_date_add_subtract DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.start_year   (start_year),
		.start_month  (start_month),
		.start_day    (start_day),
		.day_count    (day_count),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_year  (result_year),
		.result_month (result_month),
		.result_day   (result_day),
		.out_of_range (out_of_range)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// calendar predictor
	// ---------------------------------------------------------------

	// 4/100/400 rule
	function automatic bit leap_year(input int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int month_days(input int y, input int m);
		case (m)
			int'(gda_pkg::MonFeb): return leap_year(y) ? 29 : 28;
			int'(gda_pkg::MonApr), int'(gda_pkg::MonJun),
			int'(gda_pkg::MonSep), int'(gda_pkg::MonNov): return 30;
			default: return 31;
		endcase
	endfunction

	// date that lies n days after (add) or before (subtract) the start date,
	// walked one month at a time; out of range echoes the raw start fields
	function automatic date_beat_t shift_date(input logic k,
			input logic [gda_pkg::YearW-1:0] sy, input logic [gda_pkg::MonthW-1:0] sm,
			input logic [gda_pkg::DayW-1:0] sd, input logic [gda_pkg::CountW-1:0] n);
		date_beat_t res;
		int y;
		int m;
		int d;
		int rem;
		bit oor;
		y = int'(sy);
		m = int'(sm);
		d = int'(sd);
		oor = 1'b0;
		if (y < int'(gda_pkg::YearMin) || y > int'(gda_pkg::YearMax)) begin
			oor = 1'b1;
		end else begin
			// clamp month and day into the calendar before walking
			if (m < int'(gda_pkg::MonJan)) m = int'(gda_pkg::MonJan);
			if (m > int'(gda_pkg::MonDec)) m = int'(gda_pkg::MonDec);
			if (d < 1) d = 1;
			if (d > month_days(y, m)) d = month_days(y, m);
			if (k == gda_pkg::KindAdd) begin
				rem = d + int'(n);
				while (!oor && rem > month_days(y, m)) begin
					rem -= month_days(y, m);
					m++;
					if (m > int'(gda_pkg::MonDec)) begin
						m = int'(gda_pkg::MonJan);
						y++;
						if (y > int'(gda_pkg::YearMax)) oor = 1'b1;
					end
				end
				d = rem;
			end else begin
				// using up the whole day of month steps to the end of the previous month
				rem = int'(n);
				while (!oor && rem >= d) begin
					rem -= d;
					if (m == int'(gda_pkg::MonJan)) begin
						m = int'(gda_pkg::MonDec);
						y--;
						if (y < int'(gda_pkg::YearMin)) oor = 1'b1;
					end else begin
						m--;
					end
					if (!oor) d = month_days(y, m);
				end
				if (!oor) d -= rem;
			end
		end
		if (oor) begin
			res.year = sy;
			res.month = sm;
			res.day = sd;
		end else begin
			res.year = y[gda_pkg::YearW-1:0];
			res.month = m[gda_pkg::MonthW-1:0];
			res.day = d[gda_pkg::DayW-1:0];
		end
		res.oor = oor;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// result side: ready pattern, checking, watchdog
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// ready follows the stall chance, except during a requested long hold;
	// the hold is counted here so the sender keeps offering beats meanwhile
	always @(posedge clk) begin : drive_result_ready
		int hold_left;
		int hold_done;
		if (hold_done != hold_asked) begin
			hold_done = hold_asked;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// every result beat is matched against the oldest pending date
	always @(posedge clk) begin : check_result_beats
		date_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (out_of_range === 1'b1) results_oor++;
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("result beat %0d/%0d/%0d with no date pending",
					result_year, result_month, result_day));
			end else begin
				want = pending_dates.pop_front();
				if (result_year !== want.year)
					report_mismatch($sformatf("result_year %0d, want %0d",
						result_year, want.year));
				if (result_month !== want.month)
					report_mismatch($sformatf("result_month %0d, want %0d",
						result_month, want.month));
				if (result_day !== want.day)
					report_mismatch($sformatf("result_day %0d, want %0d",
						result_day, want.day));
				if (out_of_range !== want.oor)
					report_mismatch($sformatf("out_of_range %b, want %b",
						out_of_range, want.oor));
			end
		end
	end

	// a hung block shows as a long run of cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= StallLimit) begin
				$display("timeout: no beat for %0d cycles, %0d dates pending",
					StallLimit, pending_dates.size());
				$display("** gregorian_date_add_subtract: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------

	// offers one date beat, with a random gap first, and queues its
	// prediction once accepted; returns in the step of the accepting edge
	task automatic send_date(input logic k, input logic [gda_pkg::YearW-1:0] y,
			input logic [gda_pkg::MonthW-1:0] m, input logic [gda_pkg::DayW-1:0] d,
			input logic [gda_pkg::CountW-1:0] n);
		date_beat_t want;
		want = shift_date(k, y, m, d, n);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		start_year <= y;
		start_month <= m;
		start_day <= d;
		day_count <= n;
		do @(posedge clk); while (!(item_valid && item_ready));
		pending_dates.push_back(want);
		dates_sent++;
	endtask

	// drops valid and waits until every pending date has come back
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_dates.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// idling chances change on the falling edge so the ready process reads them cleanly
	task automatic set_idling(input int gap_pct, input int stall_pct);
		item_valid <= 1'b0;
		@(negedge clk);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// month ends, year rollover both ways, zero count
	task automatic test_rollover();
		send_date(gda_pkg::KindAdd, 14'd2024, 4'd2, 5'd29, 16'd0);
		send_date(gda_pkg::KindAdd, 14'd2023, 4'd12, 5'd31, 16'd1);
		send_date(gda_pkg::KindSub, 14'd2024, 4'd1, 5'd1, 16'd1);
		send_date(gda_pkg::KindAdd, 14'd2023, 4'd4, 5'd30, 16'd1);
		send_date(gda_pkg::KindSub, 14'd2023, 4'd7, 5'd15, 16'd0);
	endtask

	// leap years by 4, centuries that are not, and the 400-year exception
	task automatic test_leap_rules();
		send_date(gda_pkg::KindAdd, 14'd2024, 4'd2, 5'd28, 16'd1);
		send_date(gda_pkg::KindAdd, 14'd2023, 4'd2, 5'd28, 16'd1);
		send_date(gda_pkg::KindAdd, 14'd1900, 4'd2, 5'd28, 16'd1);
		send_date(gda_pkg::KindAdd, 14'd2000, 4'd2, 5'd28, 16'd1);
		send_date(gda_pkg::KindSub, 14'd2000, 4'd3, 5'd1, 16'd1);
	endtask

	// subtracting exactly the day of month lands on the last day before, never day 0
	task automatic test_whole_month_subtract();
		send_date(gda_pkg::KindSub, 14'd2023, 4'd3, 5'd5, 16'd5);
		send_date(gda_pkg::KindSub, 14'd2024, 4'd3, 5'd31, 16'd31);
	endtask

	// out-of-calendar fields: bad start years echo, month and day get clamped
	task automatic test_clamped_fields();
		send_date(gda_pkg::KindAdd, 14'd0, 4'd5, 5'd10, 16'd3);
		send_date(gda_pkg::KindSub, 14'h3fff, 4'hf, 5'h1f, 16'hffff);
		send_date(gda_pkg::KindAdd, 14'd2021, 4'd0, 5'd10, 16'd2);
		send_date(gda_pkg::KindSub, 14'd2021, 4'd15, 5'd10, 16'd2);
		send_date(gda_pkg::KindAdd, 14'd2022, 4'd6, 5'd0, 16'd0);
		send_date(gda_pkg::KindAdd, 14'd2023, 4'd2, 5'd31, 16'd0);
		send_date(gda_pkg::KindSub, 14'd2023, 4'd4, 5'd31, 16'd0);
	endtask

	// walking past year 9999 or below year 1, and the longest walks inside range
	task automatic test_range_limits();
		send_date(gda_pkg::KindAdd, 14'd9999, 4'd12, 5'd31, 16'd1);
		send_date(gda_pkg::KindAdd, 14'd9999, 4'd12, 5'd31, 16'hffff);
		send_date(gda_pkg::KindSub, 14'd1, 4'd1, 5'd1, 16'd1);
		send_date(gda_pkg::KindSub, 14'd1, 4'd1, 5'd1, 16'hffff);
		send_date(gda_pkg::KindAdd, 14'd1, 4'd1, 5'd1, 16'hffff);
		send_date(gda_pkg::KindSub, 14'd9999, 4'd12, 5'd31, 16'hffff);
	endtask

	// mostly well-formed dates with short counts; some near the year limits,
	// some full-width counts and some raw noise in every field
	task automatic test_random_dates(input int n);
		logic                       k;
		logic [gda_pkg::YearW-1:0]  y;
		logic [gda_pkg::MonthW-1:0] m;
		logic [gda_pkg::DayW-1:0]   d;
		logic [gda_pkg::CountW-1:0] cnt;
		int sel;
		int span;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			span = $urandom_range(99);
			k = 1'($urandom_range(1));
			if (sel < 12) begin
				y = gda_pkg::YearW'($urandom_range(16383));
				m = gda_pkg::MonthW'($urandom_range(15));
				d = gda_pkg::DayW'($urandom_range(31));
			end else begin
				if (sel < 22)
					y = (k == gda_pkg::KindSub) ? gda_pkg::YearW'($urandom_range(1, 30))
						: gda_pkg::YearW'($urandom_range(9970, 9999));
				else
					y = gda_pkg::YearW'($urandom_range(1, 9999));
				m = gda_pkg::MonthW'($urandom_range(1, 12));
				d = gda_pkg::DayW'($urandom_range(1, month_days(int'(y), int'(m))));
			end
			if (sel >= 12 && sel < 22)
				cnt = gda_pkg::CountW'($urandom_range(16383));
			else if (span < 70)
				cnt = gda_pkg::CountW'($urandom_range(400));
			else if (span < 92)
				cnt = gda_pkg::CountW'($urandom_range(4000));
			else
				cnt = gda_pkg::CountW'($urandom_range(65535));
			send_date(k, y, m, d, cnt);
		end
	endtask

	// receiver holds off for a long stretch while short items keep coming,
	// so the result register fills and item_ready has to drop
	task automatic test_result_backpressure();
		logic [gda_pkg::YearW-1:0]  y;
		logic [gda_pkg::MonthW-1:0] m;
		settle();
		@(negedge clk);
		hold_asked++;
		@(posedge clk);
		for (int i = 0; i < 12; i++) begin
			y = gda_pkg::YearW'($urandom_range(1, 9999));
			m = gda_pkg::MonthW'($urandom_range(1, 12));
			send_date(1'($urandom_range(1)), y, m,
				gda_pkg::DayW'($urandom_range(1, month_days(int'(y), int'(m)))),
				gda_pkg::CountW'($urandom_range(60)));
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver stalls often
		set_idling(27, 67);
		test_rollover();
		test_leap_rules();
		test_whole_month_subtract();
		test_clamped_fields();
		test_range_limits();
		test_random_dates(80);

		// sender idles often, receiver rarely
		settle();
		set_idling(67, 27);
		test_random_dates(80);

		// both sides at full rate
		settle();
		set_idling(0, 0);
		test_random_dates(60);
		test_result_backpressure();

		settle();
		repeat (20) @(posedge clk);
		$display("sent %0d dates (add and subtract, leap rules, clamped fields, year limits)",
			dates_sent);
		$display("checked %0d result beats, %0d out of range, %0d mismatches",
			results_seen, results_oor, mismatches);
		if (mismatches == 0)
			$display("** gregorian_date_add_subtract: PASSED **");
		else
			$display("** gregorian_date_add_subtract: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
src/gda_pkg.sv
src/gda_dp.sv
src/gda_ctrl.sv
src/gregorian_date_add_subtract.sv
test/gregorian_date_add_subtract_test.sv
